// ===== design/wmv_pkg.sv =====
// Shared types and constants of the weighted moving variance block.
`timescale 1ns / 1ps
`default_nettype none
package wmv_pkg;

	// Frame store geometry.
	localparam int FRAME_PIXELS = 65536;
	localparam int ADDR_W       = $clog2(FRAME_PIXELS);
	localparam int PIX_W        = 24;

	// Deviation unit: three arithmetic stages, then one stage per root bit.
	localparam int ROOT_BITS = 8;
	localparam int DEV_LAT   = 3 + ROOT_BITS;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_WEIGHTED_MODE    = 2'd0,
		REG_THRESHOLD_ENABLE = 2'd1,
		REG_THRESHOLD_LEVEL  = 2'd2,
		REG_COLOR_MODE       = 2'd3
	} cfg_reg_t;

	// Per-pixel control that travels beside the deviation pipeline.
	typedef struct packed {
		logic       valid;
		logic       produce;
		logic       last;
		logic       color;
		logic       thr_en;
		logic [7:0] thr_lvl;
	} pix_meta_t;

endpackage
`default_nettype wire

// ===== design/wmv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module wmv_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule
`default_nettype wire

// ===== design/wmv_dev.sv =====
// Per-channel deviation pipeline: weighted mean, weighted squared deviations, rounded root.
`timescale 1ns / 1ps
`default_nettype none
module wmv_dev (
	input  wire logic       clk,
	input  wire logic       en,
	input  wire logic       weighted,
	input  wire logic [7:0] x0,
	input  wire logic [7:0] x1,
	input  wire logic [7:0] x2,
	output      logic [7:0] dev
);
	import wmv_pkg::*;

	logic [11:0] m_s1;
	logic [7:0]  x_s1 [3];
	logic        wm_s1;
	logic [22:0] sq_s2 [3];
	logic        wm_s2;
	logic [27:0] s4_s3;

	logic [11:0] w0x0;
	logic [11:0] w2x2;
	logic [11:0] w1x1;

	// Stage 1: sum with weights in tenths, ten times the weighted mean in weighted mode.
	always_comb begin
		w0x0 = weighted ? ({4'd0, x0} << 2) + {4'd0, x0}
		                : ({4'd0, x0} << 1) + {4'd0, x0};
		w1x1 = ({4'd0, x1} << 1) + {4'd0, x1};
		w2x2 = weighted ? ({4'd0, x2} << 1)
		                : ({4'd0, x2} << 1) + {4'd0, x2};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1    <= w0x0 + w1x1 + w2x2;
			x_s1[0] <= x0;
			x_s1[1] <= x1;
			x_s1[2] <= x2;
			wm_s1   <= weighted;
		end
	end

	// Stage 2: squared deviations of ten times each sample from the mean.
	logic signed [12:0] d   [3];
	logic signed [25:0] dsq [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d[i]   = $signed({1'b0, ({4'd0, x_s1[i]} << 3) + ({4'd0, x_s1[i]} << 1)})
			       - $signed({1'b0, m_s1});
			dsq[i] = d[i] * d[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= dsq[i][22:0];
			end
			wm_s2 <= wm_s1;
		end
	end

	// Stage 3: weighted sum, times four for the rounding compare.
	logic [25:0] t0;
	logic [25:0] t1;
	logic [25:0] t2;
	logic [25:0] ssum;
	always_comb begin
		t0   = wm_s2 ? ({3'd0, sq_s2[0]} << 2) + {3'd0, sq_s2[0]}
		             : ({3'd0, sq_s2[0]} << 1) + {3'd0, sq_s2[0]};
		t1   = ({3'd0, sq_s2[1]} << 1) + {3'd0, sq_s2[1]};
		t2   = wm_s2 ? ({3'd0, sq_s2[2]} << 1)
		             : ({3'd0, sq_s2[2]} << 1) + {3'd0, sq_s2[2]};
		ssum = t0 + t1 + t2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s4_s3 <= {ssum, 2'b00};
		end
	end

	// Root stages: one result bit per stage, largest n with 1000*(2n-1)^2 <= 4*S.
	logic [7:0]  root_s [ROOT_BITS+1];
	logic [27:0] s4_s   [ROOT_BITS];
	assign root_s[0] = '0;
	assign s4_s[0]   = s4_s3;

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
		logic [7:0]  trial;
		logic [8:0]  odd;
		logic [17:0] odd_sq;
		logic [27:0] lhs;
		always_comb begin
			trial  = root_s[k] | (8'd1 << (ROOT_BITS - 1 - k));
			odd    = {trial, 1'b0} - 9'd1;
			odd_sq = odd * odd;
			lhs    = ({10'd0, odd_sq} << 10) - ({10'd0, odd_sq} << 4)
			       - ({10'd0, odd_sq} << 3);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k+1] <= (lhs <= s4_s[k]) ? trial : root_s[k];
			end
		end
		// The last stage has no later stage that needs the sum.
		if (k < ROOT_BITS - 1) begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					s4_s[k+1] <= s4_s[k];
				end
			end
		end
	end

	assign dev = root_s[ROOT_BITS];

endmodule
`default_nettype wire

// ===== design/weighted_moving_variance_bgs.sv =====
// Top level of the weighted moving variance background subtractor.
// Accepts one pixel per clock when the output does not stall and, from
// the third frame on, gives one result per pixel after the frame store
// read, the deviation pipeline and the output register. The rate is set
// by the two frame stores, which are read once and written once per pixel,
// with a same-entry forward covering a read that meets the write of the
// pixel before it. The first two frames only fill the stores. Back-pressure
// on the output stalls the whole pipeline, so in_ready follows out_ready
// whenever a result is waiting.
`timescale 1ns / 1ps
`default_nettype none
module weighted_moving_variance_bgs (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic [7:0] blue,
	input  wire logic [7:0] green,
	input  wire logic [7:0] red,
	input  wire logic       frame_end,
	output      logic       out_valid,
	input  wire logic       out_ready,
	output      logic [7:0] level,
	output      logic       frame_last,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);
	import wmv_pkg::*;

	logic              weighted_q;
	logic              thr_en_q;
	logic [7:0]        thr_lvl_q;
	logic              color_q;
	logic [ADDR_W-1:0] pixel_index_q;
	logic [1:0]        frames_seen_q;
	logic              out_valid_q;
	logic [7:0]        level_q;
	logic              last_q;

	logic en;
	logic accept;
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;
	assign accept   = en && in_valid;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weighted_q <= 1'b1;
			thr_en_q   <= 1'b1;
			thr_lvl_q  <= 8'd15;
			color_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WEIGHTED_MODE:    weighted_q <= cfg_data[0];
				REG_THRESHOLD_ENABLE: thr_en_q   <= cfg_data[0];
				REG_THRESHOLD_LEVEL:  thr_lvl_q  <= cfg_data;
				REG_COLOR_MODE:       color_q    <= cfg_data[0];
			endcase
		end
	end

	// Frame position tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_index_q <= '0;
			frames_seen_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				pixel_index_q <= '0;
				if (frames_seen_q != 2'd2) begin
					frames_seen_q <= frames_seen_q + 2'd1;
				end
			end else if (pixel_index_q == ADDR_W'(FRAME_PIXELS - 1)) begin
				pixel_index_q <= '0;
			end else begin
				pixel_index_q <= pixel_index_q + 1'b1;
			end
		end
	end

	// Stage 1 registers: the pixel whose store data arrives this cycle.
	pix_meta_t         meta_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [PIX_W-1:0]  cur_s1;
	logic              fwd_s1;
	logic [PIX_W-1:0]  fwd_prev_s1;
	logic [PIX_W-1:0]  fwd_old_s1;
	logic [PIX_W-1:0]  prev_rd;
	logic [PIX_W-1:0]  old_rd;
	logic [PIX_W-1:0]  p1;
	logic [PIX_W-1:0]  p2;
	logic              store_we;

	assign p1       = fwd_s1 ? fwd_prev_s1 : prev_rd;
	assign p2       = fwd_s1 ? fwd_old_s1 : old_rd;
	assign store_we = en && meta_s1.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
		end else if (en) begin
			meta_s1.valid   <= in_valid;
			meta_s1.produce <= frames_seen_q == 2'd2;
			meta_s1.last    <= frame_end;
			meta_s1.color   <= color_q;
			meta_s1.thr_en  <= thr_en_q;
			meta_s1.thr_lvl <= thr_lvl_q;
		end
	end

	// Forward the write of the pixel ahead when both touch the same entry.
	always_ff @(posedge clk) begin
		if (en) begin
			addr_s1     <= pixel_index_q;
			cur_s1      <= {red, green, blue};
			fwd_s1      <= store_we && (addr_s1 == pixel_index_q);
			fwd_prev_s1 <= cur_s1;
			fwd_old_s1  <= p1;
		end
	end

	wmv_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_PIXELS)) u_prev_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (addr_s1),
		.wdata (cur_s1),
		.re    (en),
		.raddr (pixel_index_q),
		.rdata (prev_rd)
	);

	wmv_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_PIXELS)) u_old_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (addr_s1),
		.wdata (p1),
		.re    (en),
		.raddr (pixel_index_q),
		.rdata (old_rd)
	);

	// One deviation pipeline per channel: blue, green, red.
	logic [7:0] dev_ch [3];
	for (genvar c = 0; c < 3; c++) begin : g_ch
		wmv_dev u_dev (
			.clk      (clk),
			.en       (en),
			.weighted (weighted_q),
			.x0       (cur_s1[8*c +: 8]),
			.x1       (p1[8*c +: 8]),
			.x2       (p2[8*c +: 8]),
			.dev      (dev_ch[c])
		);
	end

	// Control delay line matching the deviation pipeline.
	pix_meta_t meta_pipe_s [DEV_LAT+1];
	assign meta_pipe_s[0] = meta_s1;
	for (genvar k = 0; k < DEV_LAT; k++) begin : g_meta
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				meta_pipe_s[k+1] <= '0;
			end else if (en) begin
				meta_pipe_s[k+1] <= meta_pipe_s[k];
			end
		end
	end

	// Gray merge and threshold.
	pix_meta_t   meta_out;
	logic [22:0] gray_sum;
	logic [7:0]  gray;
	logic [7:0]  dev_sel;
	logic [7:0]  level_d;
	always_comb begin
		meta_out = meta_pipe_s[DEV_LAT];
		gray_sum = 23'd4899 * {15'd0, dev_ch[2]} + 23'd9617 * {15'd0, dev_ch[1]}
		         + 23'd1868 * {15'd0, dev_ch[0]} + 23'd8192;
		gray     = gray_sum[21:14];
		dev_sel  = meta_out.color ? gray : dev_ch[0];
		if (meta_out.thr_en) begin
			level_d = (dev_sel > meta_out.thr_lvl) ? 8'd255 : 8'd0;
		end else begin
			level_d = dev_sel;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= meta_out.valid && meta_out.produce;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			level_q <= level_d;
			last_q  <= meta_out.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign level      = level_q;
	assign frame_last = last_q;

endmodule
`default_nettype wire
